// ----- sv/lcdseq_pkg.sv -----
// shared types, command codes and init sequence tables for the lcd nibble sequencer
`timescale 1ns / 1ps

package lcdseq_pkg;

    localparam int MAX_ROWS_DEFAULT         = 4;
    localparam int POWER_UP_WAIT_MS_DEFAULT = 100;

    localparam int INIT_RESULTS = 17;
    localparam int STEP_W       = $clog2(INIT_RESULTS);
    localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_RESULTS - 1);

    localparam logic [6:0] STROBE_WAIT_MS = 7'd3;

    // register indexes on the configuration port
    localparam logic [1:0] CFG_LINES = 2'd0;
    localparam logic [1:0] CFG_COLS  = 2'd1;
    localparam logic [1:0] CFG_TALL  = 2'd2;

    typedef enum logic [2:0] {
        REQ_INIT   = 3'd0,
        REQ_CLEAR  = 3'd1,
        REQ_HOME   = 3'd2,
        REQ_CURSOR = 3'd3,
        REQ_CHAR   = 3'd4,
        REQ_FLAG   = 3'd5,
        REQ_SCROLL = 3'd6
    } req_t;

    localparam logic [2:0] FLAG_DISPLAY     = 3'd0;
    localparam logic [2:0] FLAG_CURSOR      = 3'd1;
    localparam logic [2:0] FLAG_BLINK       = 3'd2;
    localparam logic [2:0] FLAG_ENTRY_LEFT  = 3'd3;
    localparam logic [2:0] FLAG_ENTRY_SHIFT = 3'd4;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_HOME    = 8'h02;
    localparam logic [7:0] CMD_WAKE    = 8'h03;
    localparam logic [7:0] CMD_ENTRY   = 8'h04;
    localparam logic [7:0] CMD_DISPLAY = 8'h08;
    localparam logic [7:0] CMD_SHIFT   = 8'h10;
    localparam logic [7:0] CMD_FUNC    = 8'h20;
    localparam logic [7:0] CMD_DDRAM   = 8'h80;

    localparam logic [7:0] SHIFT_DISPLAY = 8'h08;
    localparam logic [7:0] SHIFT_RIGHT   = 8'h04;
    localparam logic [7:0] FUNC_2LINE    = 8'h08;
    localparam logic [7:0] FUNC_TALL     = 8'h04;
    localparam logic [7:0] ROW1_OFFSET   = 8'h40;

    localparam logic [2:0] DISP_ON     = 3'b100;
    localparam logic [1:0] ENTRY_LEFT  = 2'b10;
    localparam logic [1:0] ENTRY_SHIFT = 2'b01;

    localparam logic [3:0] WAKE_EXTRA_MS  = 4'd10;
    localparam logic [3:0] WAKE3_EXTRA_MS = 4'd3;
    localparam logic [3:0] CLEAR_EXTRA_MS = 4'd2;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] char_code;
        logic [6:0] col;
        logic [7:0] row;
        logic [2:0] flag_select;
        logic       flag_value;
    } in_word_t;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] nibble;
        logic       strobe_res;
        logic [6:0] wait_ms;
        logic       last;
    } out_word_t;

    typedef struct packed {
        logic [2:0] display_flags;
        logic [1:0] entry_flags;
        logic       tall_font_latched;
        logic [2:0] rows_in_use;
        logic [5:0] cols_in_use;
    } lcd_state_t;

    // one request ready for nibble emission; byte_val holds function set for init
    typedef struct packed {
        logic       is_init;
        logic       reg_select;
        logic [7:0] byte_val;
        logic [3:0] extra_ms;
    } job_t;

    function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic [7:0] func);
        logic [7:0] b;
        case (idx)
            3'd0, 3'd1, 3'd2: b = CMD_WAKE;
            3'd3:             b = CMD_HOME;
            3'd4:             b = func;
            3'd5:             b = CMD_DISPLAY | {5'b0, DISP_ON};
            3'd6:             b = CMD_CLEAR;
            3'd7:             b = CMD_ENTRY | {6'b0, ENTRY_LEFT};
            default:          b = CMD_CLEAR;
        endcase
        return b;
    endfunction

    function automatic logic [3:0] init_extra(input logic [2:0] idx);
        logic [3:0] e;
        case (idx)
            3'd0, 3'd1: e = WAKE_EXTRA_MS;
            3'd2:       e = WAKE3_EXTRA_MS;
            3'd6:       e = CLEAR_EXTRA_MS;
            default:    e = 4'd0;
        endcase
        return e;
    endfunction

endpackage

// ----- sv/lcdseq_decode.sv -----
// request decoder: next display state and the byte job for one request
`timescale 1ns / 1ps

module lcdseq_decode
    import lcdseq_pkg::*;
#(
    parameter int MAX_ROWS = MAX_ROWS_DEFAULT
) (
    input  in_word_t   req,
    input  lcd_state_t state_cur,
    input  logic [2:0] rows_req,
    input  logic [5:0] cols_req,
    input  logic       tall_req,
    output lcd_state_t state_next,
    output job_t       job,
    output logic       has_job
);

    localparam logic [7:0] ROW_CAP = 8'(MAX_ROWS - 1);

    logic [7:0] row_clamp;
    logic [7:0] rows_m1;
    logic [7:0] row_offset;
    logic [7:0] addr_sum;
    logic       tall_sel;
    logic [7:0] func_byte;
    logic [2:0] disp_bit;
    logic [1:0] entry_bit;
    logic [2:0] disp_new;
    logic [1:0] entry_new;

    // cursor address
    always_comb begin
        rows_m1   = {5'b0, state_cur.rows_in_use} - 8'd1;
        row_clamp = req.row;
        if (row_clamp > ROW_CAP) begin
            row_clamp = ROW_CAP;
        end
        if (row_clamp > rows_m1) begin
            row_clamp = rows_m1;
        end
        row_offset = 8'd0;
        if (state_cur.rows_in_use != 3'd0) begin
            case (row_clamp)
                8'd1:    row_offset = ROW1_OFFSET;
                8'd2:    row_offset = {2'b0, state_cur.cols_in_use};
                8'd3:    row_offset = ROW1_OFFSET + {2'b0, state_cur.cols_in_use};
                default: row_offset = 8'd0;
            endcase
        end
        addr_sum = {1'b0, req.col} + row_offset;
    end

    assign tall_sel  = tall_req && (rows_req == 3'd1);
    assign func_byte = CMD_FUNC | ((rows_req > 3'd1) ? FUNC_2LINE : 8'd0)
                     | (tall_sel ? FUNC_TALL : 8'd0);
    assign disp_bit  = 3'(DISP_ON >> req.flag_select[1:0]);
    assign entry_bit = (req.flag_select == FLAG_ENTRY_LEFT) ? ENTRY_LEFT : ENTRY_SHIFT;
    assign disp_new  = req.flag_value ? (state_cur.display_flags | disp_bit)
                                      : (state_cur.display_flags & ~disp_bit);
    assign entry_new = req.flag_value ? (state_cur.entry_flags | entry_bit)
                                      : (state_cur.entry_flags & ~entry_bit);

    always_comb begin
        state_next = state_cur;
        job        = '0;
        has_job    = 1'b1;
        case (req.req_type)
            REQ_INIT: begin
                state_next.rows_in_use       = rows_req;
                state_next.cols_in_use       = cols_req;
                state_next.tall_font_latched = tall_sel;
                state_next.display_flags     = DISP_ON;
                state_next.entry_flags       = ENTRY_LEFT;
                job.is_init                  = 1'b1;
                job.byte_val                 = func_byte;
            end
            REQ_CLEAR: begin
                job.byte_val = CMD_CLEAR;
                job.extra_ms = CLEAR_EXTRA_MS;
            end
            REQ_HOME: begin
                job.byte_val = CMD_HOME;
                job.extra_ms = CLEAR_EXTRA_MS;
            end
            REQ_CURSOR: begin
                job.byte_val = CMD_DDRAM | addr_sum;
            end
            REQ_CHAR: begin
                job.reg_select = 1'b1;
                job.byte_val   = req.char_code;
            end
            REQ_FLAG: begin
                if (req.flag_select inside {FLAG_DISPLAY, FLAG_CURSOR, FLAG_BLINK}) begin
                    state_next.display_flags = disp_new;
                    job.byte_val             = CMD_DISPLAY | {5'b0, disp_new};
                end else if (req.flag_select inside {FLAG_ENTRY_LEFT, FLAG_ENTRY_SHIFT}) begin
                    state_next.entry_flags = entry_new;
                    job.byte_val           = CMD_ENTRY | {6'b0, entry_new};
                end else begin
                    has_job = 1'b0;
                end
            end
            REQ_SCROLL: begin
                job.byte_val = CMD_SHIFT | SHIFT_DISPLAY
                             | (req.flag_value ? SHIFT_RIGHT : 8'd0);
            end
            default: begin
                has_job = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/char_lcd_nibble_command_sequencer.sv -----
// top level: request intake, nibble emitter and output register
`timescale 1ns / 1ps

// Turns character-LCD requests into nibble words for a 4-bit bus. Each command or
// character byte gives two words, high nibble first, each carrying register select,
// strobe flag and the wait in ms to apply after it; the final word of a request has
// last set. Initialize gives 17 words: one pure power-up wait, then eight bytes.
// Throughput is one output word per cycle while m_ready does not stall the output
// register; a request is taken in the cycle its predecessor's last word moves to the
// output register, and a request that gives no words leaves no job pending. An
// accepted job is registered, then its first word in the output register driving
// m_data. Configuration registers are sampled only by an initialize request.
module char_lcd_nibble_command_sequencer
    import lcdseq_pkg::*;
#(
    parameter int MAX_ROWS         = MAX_ROWS_DEFAULT,
    parameter int POWER_UP_WAIT_MS = POWER_UP_WAIT_MS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_word_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_word_t  m_data
);

    localparam logic [6:0] POWER_UP_WAIT = 7'(POWER_UP_WAIT_MS);

    logic [2:0]  rows_req_reg;
    logic [5:0]  cols_req_reg;
    logic        tall_req_reg;
    lcd_state_t  state_reg, state_next, dec_state;
    job_t        job_reg, job_next, dec_job;
    logic        dec_has_job;
    logic        job_valid_reg, job_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    out_word_t   out_word_reg, out_word_next, res_word;

    logic        accept;
    logic        emit;
    logic        job_last;
    logic [3:0]  init_t;
    logic [7:0]  cur_byte;
    logic [3:0]  cur_extra;
    logic        cur_high;

    lcdseq_decode #(
        .MAX_ROWS(MAX_ROWS)
    ) u_decode (
        .req       (s_data),
        .state_cur (state_reg),
        .rows_req  (rows_req_reg),
        .cols_req  (cols_req_reg),
        .tall_req  (tall_req_reg),
        .state_next(dec_state),
        .job       (dec_job),
        .has_job   (dec_has_job)
    );

    // current word of the pending job
    always_comb begin
        init_t   = 4'(step_reg - STEP_W'(1));
        res_word = '0;
        if (job_reg.is_init) begin
            cur_byte  = init_byte(init_t[3:1], job_reg.byte_val);
            cur_extra = init_extra(init_t[3:1]);
            cur_high  = !init_t[0];
            job_last  = (step_reg == INIT_LAST_STEP);
        end else begin
            cur_byte  = job_reg.byte_val;
            cur_extra = job_reg.extra_ms;
            cur_high  = !step_reg[0];
            job_last  = step_reg[0];
        end
        if (job_reg.is_init && step_reg == '0) begin
            res_word.wait_ms = POWER_UP_WAIT;
        end else begin
            res_word.reg_select = job_reg.reg_select;
            res_word.nibble     = cur_high ? cur_byte[7:4] : cur_byte[3:0];
            res_word.strobe_res = 1'b1;
            res_word.wait_ms    = STROBE_WAIT_MS + (cur_high ? 7'd0 : {3'b0, cur_extra});
        end
        res_word.last = job_last;
    end

    assign emit    = job_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !job_valid_reg || (emit && job_last);
    assign accept  = s_valid && s_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_word_reg;

    always_comb begin
        job_valid_next = job_valid_reg;
        job_next       = job_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        state_next     = state_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (emit) begin
            out_valid_next = 1'b1;
            out_word_next  = res_word;
            step_next      = step_reg + STEP_W'(1);
            if (job_last) begin
                job_valid_next = 1'b0;
            end
        end
        if (accept) begin
            job_valid_next = dec_has_job;
            job_next       = dec_job;
            step_next      = '0;
            state_next     = dec_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_req_reg  <= 3'd2;
            cols_req_reg  <= 6'd16;
            tall_req_reg  <= 1'b0;
            state_reg     <= '0;
            job_valid_reg <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LINES: rows_req_reg <= cfg_data[2:0];
                    CFG_COLS:  cols_req_reg <= cfg_data;
                    CFG_TALL:  tall_req_reg <= cfg_data[0];
                    default:   ;
                endcase
            end
            state_reg     <= state_next;
            job_valid_reg <= job_valid_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        out_word_reg <= out_word_next;
    end

    a_short_job_step: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && !job_reg.is_init |-> step_reg <= STEP_W'(1))
        else $error("byte job step out of range");

    a_init_job_step: assert property (@(posedge aclk) disable iff (!aresetn)
        job_valid_reg && job_reg.is_init |-> step_reg <= INIT_LAST_STEP)
        else $error("init job step out of range");

    a_wait_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.strobe_res |-> m_data.wait_ms == POWER_UP_WAIT && !m_data.last)
        else $error("pure wait word outside power-up slot");

    a_init_capture: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.req_type == REQ_INIT
        |=> state_reg.rows_in_use == $past(rows_req_reg)
            && state_reg.cols_in_use == $past(cols_req_reg))
        else $error("init did not capture geometry");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("emitted word lost");

endmodule
